FILE: hdl/pgcf_pkg.sv
// Shared types and constants for the projection gap centroid finder.
// No dependencies; used by pgcf_ram users and the top level.
package pgcf_pkg;

    localparam int MAX_BINS    = 128;
    localparam int BIN_W       = 20;
    localparam int CROSS_W     = 13;
    localparam int CENTER_W    = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 8;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = CROSS_W;

    localparam int BIN_ADDR_W  = $clog2(MAX_BINS);
    localparam int BIN_CNT_W   = $clog2(MAX_BINS + 1);
    localparam int IDX_SUM_W   = $clog2(MAX_BINS * (MAX_BINS - 1) / 2 + 1);
    localparam int DIV_STEP_W  = $clog2(IDX_SUM_W + 1);

    // Dominance test max*100 > cross*255*80 reduced by 20: max*5 > cross*1020.
    localparam int DOM_LHS_W   = BIN_W + 3;
    localparam logic [9:0] DOM_CROSS_MUL = 10'd1020;

    localparam logic [CROSS_W-1:0] CROSS_RESET = 13'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_PROJECTION_MODE = 1'b0,
        CFG_CROSS_LENGTH    = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SETUP,
        ST_FETCH,
        ST_EVAL,
        ST_DIV,
        ST_EMIT,
        ST_FLUSH
    } state_t;

endpackage

FILE: hdl/pgcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module pgcf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: hdl/projection_gap_centroid_finder.sv
// Projection gap centroid finder: stores a profile, then reports run centers.
// Depends on pgcf_pkg and pgcf_ram.
//
//  channel | direction | tdata (low bit up)        | tuser | tlast
//  --------+-----------+---------------------------+-------+-------------
//  s_      | in        | bin_sum[19:0], zero pad   | -     | last_bin
//  m_      | out       | run_center[6:0], zero pad | -     | last_center
//  cfg_    | in        | index 0 projection_mode, index 1 cross_length
//
// Sequence: one bin per cycle while loading. After the last bin: a setup state,
//   a RAM read and an evaluate state per stored bin, the shared restoring
//   divider plus an emit state per run that closes, and a flush state.
// Reset: aresetn is synchronous, active low; clears control, max, count and the
//   config registers (cross_length to 1024). The bin RAM is not cleared.
// Stalls: s_tready is low during the scan. The scan holds in emit or flush while a
//   center is held back and the output register still holds an untaken transaction.
module projection_gap_centroid_finder (
    input  logic                                aclk,
    input  logic                                aresetn,
    // input bins
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [pgcf_pkg::S_TDATA_W-1:0]      s_tdata,   // [19:0] bin_sum
    input  logic                                s_tlast,   // last_bin
    // run centers
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [pgcf_pkg::M_TDATA_W-1:0]      m_tdata,   // [6:0] run_center
    output logic                                m_tlast,   // last_center
    // configuration
    input  logic                                cfg_we,
    input  logic [pgcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pgcf_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int BW  = pgcf_pkg::BIN_W;
    localparam int AW  = pgcf_pkg::BIN_ADDR_W;
    localparam int CW  = pgcf_pkg::BIN_CNT_W;
    localparam int SW  = pgcf_pkg::IDX_SUM_W;
    localparam int DSW = pgcf_pkg::DIV_STEP_W;
    localparam int OW  = pgcf_pkg::CENTER_W;

    pgcf_pkg::state_t state_reg, state_next;

    // configuration
    logic                             projection_mode_reg;
    logic [pgcf_pkg::CROSS_W-1:0]     cross_length_reg;

    // profile bookkeeping
    logic [BW-1:0] running_max_reg, running_max_next;
    logic [CW-1:0] bin_count_reg,   bin_count_next;

    // scan state
    logic [CW-1:0] idx_reg,      idx_next;
    logic          in_run_reg,   in_run_next;
    logic [SW-1:0] idx_sum_reg,  idx_sum_next;
    logic [CW-1:0] run_len_reg,  run_len_next;
    logic          dominant_reg, dominant_next;

    // shared divider
    logic [SW-1:0]  quo_reg,  quo_next;
    logic [CW-1:0]  rem_reg,  rem_next;
    logic [DSW-1:0] step_reg, step_next;

    // one center held back until we know whether it is the final one
    logic          pend_valid_reg, pend_valid_next;
    logic [OW-1:0] pend_center_reg, pend_center_next;

    // output register
    logic          m_valid_reg,  m_valid_next;
    logic [OW-1:0] m_center_reg, m_center_next;
    logic          m_last_reg,   m_last_next;

    // RAM
    logic          ram_we;
    logic [BW-1:0] ram_rdata;

    logic          s_accept;
    logic [BW-1:0] s_bin;
    logic          out_free;
    logic          room;
    logic [BW+3:0] bin_scaled;
    logic          hit;
    logic [CW:0]   rem_shift;
    logic          rem_ge;
    logic [CW:0]   rem_sub;
    logic [pgcf_pkg::DOM_LHS_W-1:0] dom_lhs;
    logic [pgcf_pkg::DOM_LHS_W-1:0] dom_rhs;
    logic [CW-1:0] idx_inc;
    logic          scan_done;

    pgcf_ram #(
        .WIDTH (BW),
        .DEPTH (pgcf_pkg::MAX_BINS)
    ) u_bin_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (bin_count_reg[AW-1:0]),
        .wdata (s_bin),
        .raddr (idx_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == pgcf_pkg::ST_LOAD);
    assign s_accept = s_tvalid && s_tready;
    assign s_bin    = s_tdata[BW-1:0];
    // bins past the store depth are dropped but a last flag still starts the scan
    assign room     = (bin_count_reg < CW'(pgcf_pkg::MAX_BINS));
    assign ram_we   = s_accept && room;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(pgcf_pkg::M_TDATA_W - OW){1'b0}}, m_center_reg};
    assign m_tlast  = m_last_reg;
    assign out_free = !m_valid_reg || m_tready;

    // Threshold compare: horizontal bin*10 > max, vertical bin*5 > max when dominant.
    assign bin_scaled = projection_mode_reg
        ? ({1'b0, ram_rdata, 3'b000} + {3'b000, ram_rdata, 1'b0})
        : ({2'b00, ram_rdata, 2'b00} + {4'b0000, ram_rdata});
    assign hit = (bin_scaled > {4'b0000, running_max_reg})
                 && (projection_mode_reg || dominant_reg);

    // Dominance: max*5 > cross_length*1020.
    assign dom_lhs = {1'b0, running_max_reg, 2'b00} + {3'b000, running_max_reg};
    assign dom_rhs = pgcf_pkg::DOM_LHS_W'(cross_length_reg)
                     * pgcf_pkg::DOM_LHS_W'(pgcf_pkg::DOM_CROSS_MUL);

    // Restoring divider, one quotient bit per step.
    assign rem_shift = {rem_reg, quo_reg[SW-1]};
    assign rem_ge    = (rem_shift >= {1'b0, run_len_reg});
    assign rem_sub   = rem_shift - {1'b0, run_len_reg};

    assign idx_inc   = idx_reg + CW'(1);
    assign scan_done = (idx_reg == bin_count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pgcf_pkg::ST_LOAD: begin
                if (s_accept && s_tlast) begin
                    state_next = pgcf_pkg::ST_SETUP;
                end
            end
            pgcf_pkg::ST_SETUP: begin
                if (bin_count_reg == '0) begin
                    state_next = pgcf_pkg::ST_FLUSH;
                end else begin
                    state_next = pgcf_pkg::ST_FETCH;
                end
            end
            pgcf_pkg::ST_FETCH: begin
                state_next = pgcf_pkg::ST_EVAL;
            end
            pgcf_pkg::ST_EVAL: begin
                if (in_run_reg && !hit) begin
                    state_next = pgcf_pkg::ST_DIV;
                end else if (idx_inc == bin_count_reg) begin
                    state_next = pgcf_pkg::ST_FLUSH;
                end else begin
                    state_next = pgcf_pkg::ST_FETCH;
                end
            end
            pgcf_pkg::ST_DIV: begin
                if (step_reg == DSW'(SW - 1)) begin
                    state_next = pgcf_pkg::ST_EMIT;
                end
            end
            pgcf_pkg::ST_EMIT: begin
                if (!pend_valid_reg || out_free) begin
                    if (scan_done) begin
                        state_next = pgcf_pkg::ST_FLUSH;
                    end else begin
                        state_next = pgcf_pkg::ST_FETCH;
                    end
                end
            end
            pgcf_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    state_next = pgcf_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = pgcf_pkg::ST_LOAD;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        running_max_next = running_max_reg;
        bin_count_next   = bin_count_reg;
        idx_next         = idx_reg;
        in_run_next      = in_run_reg;
        idx_sum_next     = idx_sum_reg;
        run_len_next     = run_len_reg;
        dominant_next    = dominant_reg;
        quo_next         = quo_reg;
        rem_next         = rem_reg;
        step_next        = step_reg;
        pend_valid_next  = pend_valid_reg;
        pend_center_next = pend_center_reg;
        m_valid_next     = m_valid_reg && !m_tready;
        m_center_next    = m_center_reg;
        m_last_next      = m_last_reg;

        unique case (state_reg)
            pgcf_pkg::ST_LOAD: begin
                if (ram_we) begin
                    bin_count_next = bin_count_reg + CW'(1);
                    if (s_bin > running_max_reg) begin
                        running_max_next = s_bin;
                    end
                end
            end
            pgcf_pkg::ST_SETUP: begin
                dominant_next   = (dom_lhs > dom_rhs);
                idx_next        = '0;
                in_run_next     = 1'b0;
                pend_valid_next = 1'b0;
            end
            pgcf_pkg::ST_FETCH: begin
                // wait for the registered RAM read at idx_reg
            end
            pgcf_pkg::ST_EVAL: begin
                idx_next = idx_inc;
                if (hit) begin
                    if (in_run_reg) begin
                        idx_sum_next = idx_sum_reg + SW'(idx_reg);
                        run_len_next = run_len_reg + CW'(1);
                    end else begin
                        in_run_next  = 1'b1;
                        idx_sum_next = SW'(idx_reg);
                        run_len_next = CW'(1);
                    end
                end else if (in_run_reg) begin
                    // run closed: start the divider
                    in_run_next = 1'b0;
                    quo_next    = idx_sum_reg;
                    rem_next    = '0;
                    step_next   = '0;
                end
            end
            pgcf_pkg::ST_DIV: begin
                quo_next  = {quo_reg[SW-2:0], rem_ge};
                rem_next  = rem_ge ? rem_sub[CW-1:0] : rem_shift[CW-1:0];
                step_next = step_reg + DSW'(1);
            end
            pgcf_pkg::ST_EMIT: begin
                if (!pend_valid_reg) begin
                    pend_valid_next  = 1'b1;
                    pend_center_next = quo_reg[OW-1:0];
                end else if (out_free) begin
                    m_valid_next     = 1'b1;
                    m_center_next    = pend_center_reg;
                    m_last_next      = 1'b0;
                    pend_center_next = quo_reg[OW-1:0];
                end
            end
            pgcf_pkg::ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    if (pend_valid_reg) begin
                        m_valid_next  = 1'b1;
                        m_center_next = pend_center_reg;
                        m_last_next   = 1'b1;
                    end
                    pend_valid_next  = 1'b0;
                    running_max_next = '0;
                    bin_count_next   = '0;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg           <= pgcf_pkg::ST_LOAD;
            projection_mode_reg <= 1'b0;
            cross_length_reg    <= pgcf_pkg::CROSS_RESET;
            running_max_reg     <= '0;
            bin_count_reg       <= '0;
            idx_reg             <= '0;
            in_run_reg          <= 1'b0;
            dominant_reg        <= 1'b0;
            step_reg            <= '0;
            pend_valid_reg      <= 1'b0;
            m_valid_reg         <= 1'b0;
        end else begin
            state_reg       <= state_next;
            running_max_reg <= running_max_next;
            bin_count_reg   <= bin_count_next;
            idx_reg         <= idx_next;
            in_run_reg      <= in_run_next;
            dominant_reg    <= dominant_next;
            step_reg        <= step_next;
            pend_valid_reg  <= pend_valid_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_we) begin
                unique case (pgcf_pkg::cfg_index_t'(cfg_index))
                    pgcf_pkg::CFG_PROJECTION_MODE: projection_mode_reg <= cfg_wdata[0];
                    pgcf_pkg::CFG_CROSS_LENGTH:    cross_length_reg    <= cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        idx_sum_reg     <= idx_sum_next;
        run_len_reg     <= run_len_next;
        quo_reg         <= quo_next;
        rem_reg         <= rem_next;
        pend_center_reg <= pend_center_next;
        m_center_reg    <= m_center_next;
        m_last_reg      <= m_last_next;
    end

endmodule

FILE: test/projection_gap_centroid_finder_checker.sv
// Scoreboard for the projection gap centroid finder: watches the bin, center and
// config ports, predicts the run centers of every profile and compares them.
// Depends on pgcf_pkg.
module projection_gap_centroid_finder_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [pgcf_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pgcf_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                             m_tlast,
    input  logic                             cfg_we,
    input  logic [pgcf_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pgcf_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    output int                               mismatch_count,
    output int                               centers_pending,
    output int                               bins_taken,
    output int                               profiles_taken,
    output int                               centers_taken
);
    timeunit 1ns;
    timeprecision 1ps;
    import pgcf_pkg::*;

    typedef struct packed {
        logic [CENTER_W-1:0] center;
        logic                last;
    } run_center_t;

    run_center_t        expected_centers[$];
    run_center_t        got_center;
    run_center_t        want_center;

    // Shadow of the block: stored profile, its peak and the two registers.
    logic [BIN_W-1:0]   profile_bins [MAX_BINS];
    logic [BIN_W-1:0]   peak_bin;
    int unsigned        bins_stored;
    logic               horizontal;
    logic [CROSS_W-1:0] cross_len;

    function automatic void report_mismatch(input string what);
        if (mismatch_count < 10)
            $display("[%0t] run center mismatch: %s", $realtime, what);
        mismatch_count++;
    endfunction

    // Append one center at the tail of the expected queue.
    function automatic void queue_center(input run_center_t c);
        expected_centers.insert(expected_centers.size(), c);
    endfunction

    // Scan the stored profile and queue the center of every closed run.
    function automatic void predict_centers();
        longint unsigned dom_lhs;
        longint unsigned dom_rhs;
        longint unsigned level;
        logic            dominant;
        logic            hit;
        logic            in_run;
        logic            have_center;
        int unsigned     idx_sum;
        int unsigned     run_len;
        int unsigned     found;
        run_center_t     held;

        dom_lhs = peak_bin;
        dom_lhs = dom_lhs * 100;
        dom_rhs = cross_len;
        dom_rhs = dom_rhs * 255 * 80;
        dominant = dom_lhs > dom_rhs;
        in_run = 1'b0;
        have_center = 1'b0;
        idx_sum = 0;
        run_len = 0;
        found = 0;
        held = '0;
        for (int i = 0; i < bins_stored; i++) begin
            level = profile_bins[i];
            if (horizontal)
                hit = (level * 10) > peak_bin;
            else
                hit = dominant && ((level * 5) > peak_bin);
            if (!in_run) begin
                if (hit) begin
                    in_run = 1'b1;
                    idx_sum = i;
                    run_len = 1;
                end
            end else if (!hit) begin
                in_run = 1'b0;
                if (found < MAX_BINS / 2) begin
                    // hold back one center so the final one can be flagged
                    if (have_center)
                        queue_center(held);
                    held.center = CENTER_W'(idx_sum / run_len);
                    held.last = 1'b0;
                    have_center = 1'b1;
                    found++;
                end
            end else begin
                idx_sum += i;
                run_len++;
            end
        end
        if (have_center) begin
            held.last = 1'b1;
            queue_center(held);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            expected_centers.delete();
            peak_bin = '0;
            bins_stored = 0;
            horizontal = 1'b0;
            cross_len = CROSS_RESET;
            mismatch_count = 0;
            bins_taken = 0;
            profiles_taken = 0;
            centers_taken = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_PROJECTION_MODE: horizontal = cfg_wdata[0];
                    CFG_CROSS_LENGTH:    cross_len = cfg_wdata[CROSS_W-1:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                bins_taken++;
                if (bins_stored < MAX_BINS) begin
                    profile_bins[bins_stored] = s_tdata[BIN_W-1:0];
                    bins_stored++;
                    if (s_tdata[BIN_W-1:0] > peak_bin)
                        peak_bin = s_tdata[BIN_W-1:0];
                end
                if (s_tlast) begin
                    predict_centers();
                    profiles_taken++;
                    peak_bin = '0;
                    bins_stored = 0;
                end
            end
            if (m_tvalid && m_tready) begin
                centers_taken++;
                got_center.center = m_tdata[CENTER_W-1:0];
                got_center.last = m_tlast;
                if (expected_centers.size() == 0) begin
                    report_mismatch($sformatf("center %0d last %0b with nothing expected",
                                              got_center.center, got_center.last));
                end else begin
                    want_center = expected_centers.pop_front();
                    if (got_center.center !== want_center.center ||
                        got_center.last !== want_center.last)
                        report_mismatch($sformatf(
                            "center %0d last %0b, expected center %0d last %0b",
                            got_center.center, got_center.last,
                            want_center.center, want_center.last));
                end
            end
        end
        centers_pending = expected_centers.size();
    end

endmodule

FILE: test/projection_gap_centroid_finder_tb.sv
// Top of the projection gap centroid finder testbench: clock, reset, bin and
// config stimulus, receiver back-pressure and the verdict.
// Depends on pgcf_pkg, the block and projection_gap_centroid_finder_checker.
module projection_gap_centroid_finder_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import pgcf_pkg::*;

    // Bins to send in the random part, the long comb profile included.
    localparam int RANDOM_BINS     = 140;
    // Worst scan after the final center: setup plus read and evaluate per bin.
    localparam int SCAN_TAIL       = 2 * MAX_BINS + 64;
    // Long receiver hold-off, meant to outlast loading of the long profile.
    localparam int HOLD_OFF_CYCLES = 3000;
    // Watchdog limit, well above what the slowest correct run needs.
    localparam int LIMIT_CYCLES    = 600000;

    typedef enum int {
        SHAPE_NOISE,
        SHAPE_BLOCKS,
        SHAPE_MIXED
    } profile_shape_t;

    bit                     aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;

    int mismatch_count;
    int centers_pending;
    int bins_taken;
    int profiles_taken;
    int centers_taken;

    logic [BIN_W-1:0] profile_q[$];
    logic             gapless;
    logic             hold_off_req;
    logic             hold_off_done;
    int               reg_writes;
    int               cycle_count;

    projection_gap_centroid_finder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    projection_gap_centroid_finder_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tlast         (s_tlast),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tlast         (m_tlast),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .mismatch_count  (mismatch_count),
        .centers_pending (centers_pending),
        .bins_taken      (bins_taken),
        .profiles_taken  (profiles_taken),
        .centers_taken   (centers_taken)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run.
    initial begin
        cycle_count = 0;
        forever begin
            @(posedge aclk);
            cycle_count++;
            if (cycle_count > LIMIT_CYCLES) begin
                $display("timeout after %0d cycles, %0d centers still expected",
                         cycle_count, centers_pending);
                $display("projection_gap_centroid_finder_tb NOT OK");
                $finish;
            end
        end
    end

    // Receiver: random ready with bursts and stalls, plus one long hold-off
    // while a long profile is in flight so the scan backs up into s_tready.
    initial begin
        int r;
        m_tready = 1'b0;
        hold_off_done = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_off_req && !hold_off_done) begin
                hold_off_done = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge aclk);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 50) begin
                    m_tready <= 1'b1;
                end else if (r < 75) begin
                    m_tready <= 1'b0;
                end else if (r < 90) begin
                    // stretch with no stall at all
                    m_tready <= 1'b1;
                    repeat ($urandom_range(10, 50)) @(negedge aclk);
                end else begin
                    m_tready <= 1'b0;
                    repeat ($urandom_range(5, 40)) @(negedge aclk);
                end
            end
        end
    end

    // Append one bin at the tail of the profile being built.
    function automatic void add_bin(input logic [BIN_W-1:0] value);
        profile_q.insert(profile_q.size(), value);
    endfunction

    // Mostly back-to-back, sometimes a short gap, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offer one bin and hold it until the transaction completes. Entered and
    // left at a falling edge; tvalid stays high when the next bin follows at once.
    task automatic send_bin(input logic [BIN_W-1:0] value, input logic last_one);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            s_tdata  <= S_TDATA_W'($urandom);
            s_tlast  <= 1'($urandom_range(0, 1));
            repeat (gap) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(value);
        s_tlast  <= last_one;
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    task automatic send_profile();
        for (int i = 0; i < profile_q.size(); i++)
            send_bin(profile_q[i], i == profile_q.size() - 1);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
        reg_writes++;
    endtask

    // Drop tvalid, drain every expected center, then let a scan that reports
    // nothing more run out before touching the registers.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (centers_pending != 0) @(negedge aclk);
        repeat (SCAN_TAIL) @(negedge aclk);
    endtask

    // A level close to what decides a bin: zero, anything, either threshold
    // give or take one, or close to the peak.
    function automatic logic [BIN_W-1:0] near_level(input logic [BIN_W-1:0] peak);
        int v;
        case ($urandom_range(0, 5))
            0:       v = 0;
            1:       v = $urandom_range(0, peak);
            2:       v = int'(peak) / 10 + $urandom_range(0, 2) - 1;
            3:       v = int'(peak) / 5 + $urandom_range(0, 2) - 1;
            default: v = int'(peak) - $urandom_range(0, peak / 4);
        endcase
        if (v < 0)
            v = 0;
        return BIN_W'(v);
    endfunction

    task automatic build_profile(input int len, input profile_shape_t shape);
        logic [BIN_W-1:0] peak;
        logic             high;
        int               run_left;
        int               r;
        profile_q.delete();
        r = $urandom_range(0, 9);
        if (r < 2)
            peak = '1;
        else if (r < 4)
            peak = BIN_W'($urandom_range(1, 5000));
        else
            peak = BIN_W'($urandom_range(150000, (1 << BIN_W) - 1));
        high = 1'b1;
        run_left = 0;
        for (int i = 0; i < len; i++) begin
            case (shape)
                SHAPE_NOISE: begin
                    add_bin(BIN_W'($urandom));
                end
                SHAPE_BLOCKS: begin
                    // alternate blocks of strong and weak bins
                    if (run_left == 0) begin
                        high = ~high;
                        run_left = high ? $urandom_range(1, 4) : $urandom_range(1, 3);
                    end
                    run_left--;
                    if (high)
                        add_bin(peak - BIN_W'($urandom_range(0, peak / 2)));
                    else
                        add_bin(BIN_W'($urandom_range(0, peak / 10)));
                end
                default: begin
                    add_bin(near_level(peak));
                end
            endcase
        end
        // make sure the chosen peak really is the maximum
        if (shape != SHAPE_NOISE)
            profile_q[$urandom_range(0, len - 1)] = peak;
    endtask

    // One-bin runs on every even index: the most centers a scan can report.
    // The bins past the store are dropped, strong ones included.
    task automatic build_comb(input int len);
        logic [BIN_W-1:0] peak;
        profile_q.delete();
        peak = BIN_W'($urandom_range(1000, 500000));
        for (int i = 0; i < len; i++) begin
            if (i >= MAX_BINS)
                add_bin(BIN_W'($urandom));
            else if (i % 2 == 0)
                add_bin(peak);
            else
                add_bin(BIN_W'($urandom_range(0, peak / 10)));
        end
    endtask

    initial begin
        int sent;
        int len;
        int pick;
        int phase;
        profile_shape_t shape;

        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_PROJECTION_MODE;
        cfg_wdata = '0;
        gapless = 1'b0;
        hold_off_req = 1'b0;
        reg_writes = 0;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part, first under the reset settings: vertical, 1024 wide.
        // Full-scale peaks pass the dominance test: centers 0 and 2.
        profile_q = '{20'hFFFFF, 20'h0, 20'hFFFFF, 20'h0};
        send_profile();
        // All-zero profile: nothing to report.
        profile_q = '{20'h0, 20'h0, 20'h0};
        send_profile();
        // Weak maximum fails the dominance test: nothing to report.
        profile_q = '{20'd1000, 20'd0, 20'd1000, 20'd0};
        send_profile();
        // A run still open at the last bin is not reported.
        profile_q = '{20'hFFFFF};
        send_profile();

        wait_idle();
        write_reg(CFG_PROJECTION_MODE, CFG_DATA_W'(1));
        // Horizontal: one run over bins 1..3, center 2.
        profile_q = '{20'd0, 20'd100, 20'd100, 20'd100, 20'd5, 20'd0};
        send_profile();
        // A bin at exactly a tenth of the max does not count: center 1 only.
        profile_q = '{20'd10, 20'd100, 20'd0};
        send_profile();

        wait_idle();
        write_reg(CFG_PROJECTION_MODE, CFG_DATA_W'(0));
        write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'(0));
        // Zero cross length: any nonzero max is dominant. Centers 0 and 2.
        profile_q = '{20'd1, 20'd0, 20'd1, 20'd1, 20'd0};
        send_profile();

        // Random part: each phase picks a setting, then sends a few profiles.
        sent = 0;
        phase = 0;
        while (sent < RANDOM_BINS) begin
            wait_idle();
            if (phase == 0) begin
                write_reg(CFG_PROJECTION_MODE, CFG_DATA_W'(1));
                write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'((1 << CROSS_W) - 1));
                // Long comb while the receiver holds off; the profiles after it
                // keep offering bins against a stalled scan.
                hold_off_req = 1'b1;
                build_comb(MAX_BINS + 2);
                send_profile();
                sent += MAX_BINS + 2;
            end else begin
                write_reg(CFG_PROJECTION_MODE,
                          CFG_DATA_W'(phase == 1 ? 0 : $urandom_range(0, 1)));
                case ((phase - 1) % 5)
                    0:       write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'(1));
                    1:       write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'(4096));
                    2:       write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'(1024));
                    3:       write_reg(CFG_CROSS_LENGTH, CFG_DATA_W'(0));
                    default: write_reg(CFG_CROSS_LENGTH,
                                       CFG_DATA_W'($urandom_range(1, (1 << CROSS_W) - 1)));
                endcase
            end
            repeat ($urandom_range(2, 4)) begin
                gapless = ($urandom_range(0, 3) == 0);
                pick = $urandom_range(0, 99);
                if (pick < 3)
                    len = $urandom_range(MAX_BINS - 2, MAX_BINS + 4);
                else if (pick < 10)
                    len = $urandom_range(16, 32);
                else
                    len = $urandom_range(1, 8);
                pick = $urandom_range(0, 99);
                if (pick < 25)
                    shape = SHAPE_NOISE;
                else if (pick < 45)
                    shape = SHAPE_BLOCKS;
                else
                    shape = SHAPE_MIXED;
                build_profile(len, shape);
                send_profile();
                sent += len;
            end
            gapless = 1'b0;
            phase++;
        end

        wait_idle();
        $display("sent %0d bins in %0d profiles over %0d register writes;",
                 bins_taken, profiles_taken, reg_writes);
        $display("checked %0d run centers, %0d mismatching", centers_taken, mismatch_count);
        if (mismatch_count == 0 && centers_pending == 0) begin
            $display("projection_gap_centroid_finder_tb OK");
        end else begin
            $display("projection_gap_centroid_finder_tb NOT OK");
        end
        $finish;
    end

endmodule
